FILE: rtl/pt_comp_pkg.sv
package pt_comp_pkg;

  localparam int CfgIdxW   = 3;
  localparam int CalW      = 16;
  localparam int RawW      = 24;
  localparam int TempW     = 19;
  localparam int PresW     = 32;
  localparam int NumStages = 9;

  localparam int TempRef     = 2000;
  localparam int ColdRef     = 1500;
  localparam int DivSens     = 2097152;
  localparam int DivOff      = 8192;
  localparam int TempShift   = 23;
  localparam int OffShift    = 7;
  localparam int SensShift   = 8;
  localparam int TiHotShift  = 36;
  localparam int TiColdShift = 33;

  localparam int PresMax = 32'sh7fffffff;
  localparam int PresMin = -PresMax - 1;

  typedef enum logic [CfgIdxW-1:0] {
    RegC1 = 3'd0,
    RegC2 = 3'd1,
    RegC3 = 3'd2,
    RegC4 = 3'd3,
    RegC5 = 3'd4,
    RegC6 = 3'd5
  } cfg_reg_e;

endpackage

FILE: rtl/pressure_temperature_compensation.sv
// Throughput: one request per cycle unless out_stall_i holds a full pipeline; nine register
// stages, the widest being the 25x25 square, the 24x42 pressure product split into two
// partial products, and the two truncating divides each in its own stage.
// Reset: asynchronous, active low; clears calibration words to zero and all valid bits.
module pressure_temperature_compensation
  import pt_comp_pkg::*;
(
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    cfg_we_i,
  input  logic [CfgIdxW-1:0]      cfg_idx_i,
  input  logic [CalW-1:0]         cfg_data_i,
  input  logic                    in_valid_i,
  output logic                    in_stall_o,
  input  logic [RawW-1:0]         raw_pressure_i,
  input  logic [RawW-1:0]         raw_temperature_i,
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output logic signed [TempW-1:0] temperature_centi_o,
  output logic signed [PresW-1:0] pressure_deci_mbar_o
);

  logic [CalW-1:0] c1_q, c2_q, c3_q, c4_q, c5_q, c6_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c1_q <= '0;
      c2_q <= '0;
      c3_q <= '0;
      c4_q <= '0;
      c5_q <= '0;
      c6_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        RegC1:   c1_q <= cfg_data_i;
        RegC2:   c2_q <= cfg_data_i;
        RegC3:   c3_q <= cfg_data_i;
        RegC4:   c4_q <= cfg_data_i;
        RegC5:   c5_q <= cfg_data_i;
        RegC6:   c6_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // stage handshake
  logic [NumStages-1:0] valid_q;
  logic [NumStages-1:0] stage_en;

  always_comb begin
    stage_en[NumStages-1] = !valid_q[NumStages-1] || !out_stall_i;
    for (int k = NumStages - 2; k >= 0; k--) begin
      stage_en[k] = !valid_q[k] || stage_en[k+1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      if (stage_en[0]) valid_q[0] <= in_valid_i;
      for (int k = 1; k < NumStages; k++) begin
        if (stage_en[k]) valid_q[k] <= valid_q[k-1];
      end
    end
  end

  assign in_stall_o  = !stage_en[0];
  assign out_valid_o = valid_q[NumStages-1];

  // stage 1: dT
  logic signed [24:0] dt_d;
  logic [RawW-1:0]    s1_d1_q;
  logic signed [24:0] s1_dt_q;

  assign dt_d = $signed({1'b0, raw_temperature_i}) - $signed({1'b0, c5_q, 8'b0});

  // stage 2: products with dT
  logic signed [41:0] p6_d, p4_d, p3_d;
  logic signed [49:0] dt2_full;
  logic [RawW-1:0]    s2_d1_q;
  logic signed [41:0] s2_p6_q, s2_p4_q, s2_p3_q;
  logic [48:0]        s2_dt2_q;

  assign p6_d     = s1_dt_q * $signed({1'b0, c6_q});
  assign p4_d     = s1_dt_q * $signed({1'b0, c4_q});
  assign p3_d     = s1_dt_q * $signed({1'b0, c3_q});
  assign dt2_full = s1_dt_q * s1_dt_q;

  // stage 3: TEMP, OFF, SENS, range flags
  logic signed [18:0] d_d;
  logic signed [19:0] temp_d, e_d;
  logic signed [35:0] off_d, sens_d;
  logic               hot_d, cold_d;
  logic [RawW-1:0]    s3_d1_q;
  logic [48:0]        s3_dt2_q;
  logic signed [18:0] s3_d_q;
  logic signed [19:0] s3_e_q, s3_temp_q;
  logic signed [35:0] s3_off_q, s3_sens_q;
  logic               s3_hot_q, s3_cold_q;

  assign d_d    = 19'(s2_p6_q >>> TempShift);
  assign temp_d = {d_d[18], d_d} + 20'(TempRef);
  assign e_d    = {d_d[18], d_d} + 20'(TempRef + ColdRef);
  assign off_d  = $signed({4'b0, c2_q, 16'b0}) + 36'(s2_p4_q >>> OffShift);
  assign sens_d = $signed({5'b0, c1_q, 15'b0}) + 36'(s2_p3_q >>> SensShift);
  assign hot_d  = !d_d[18] && (|d_d);
  assign cold_d = e_d[19];

  // stage 4: squares, TI
  logic signed [37:0] dsq_full;
  logic signed [39:0] esq_full;
  logic [50:0]        dt2x3;
  logic [17:0]        ti_d;
  logic signed [20:0] tout_d;
  logic [RawW-1:0]    s4_d1_q;
  logic [36:0]        s4_dsq_q, s4_esq_q;
  logic signed [35:0] s4_off_q, s4_sens_q;
  logic               s4_hot_q, s4_cold_q;
  logic [TempW-1:0]   s4_tout_q;

  assign dsq_full = s3_d_q * s3_d_q;
  assign esq_full = s3_e_q * s3_e_q;
  assign dt2x3    = {2'b0, s3_dt2_q} + {1'b0, s3_dt2_q, 1'b0};
  assign ti_d     = s3_hot_q ? 18'(s3_dt2_q >> TiHotShift) : 18'(dt2x3 >> TiColdShift);
  assign tout_d   = {s3_temp_q[19], s3_temp_q} - $signed({3'b0, ti_d});

  // stage 5: OFFI, SENSI, differences
  logic [40:0]        dsq41, esq41, offi_d, sensi_d;
  logic signed [41:0] sdiff_d, odiff_d;
  logic [RawW-1:0]    s5_d1_q;
  logic signed [41:0] s5_sdiff_q, s5_odiff_q;
  logic [TempW-1:0]   s5_tout_q;

  assign dsq41 = {4'b0, s4_dsq_q};
  assign esq41 = {4'b0, s4_esq_q};

  always_comb begin
    if (s4_hot_q) begin
      offi_d  = dsq41 >> 4;
      sensi_d = '0;
    end else begin
      offi_d  = (dsq41 + (dsq41 << 1)) >> 1;
      sensi_d = ((dsq41 << 2) + dsq41) >> 3;
      if (s4_cold_q) begin
        offi_d  = offi_d + ((esq41 << 3) - esq41);
        sensi_d = sensi_d + (esq41 << 2);
      end
    end
  end

  assign sdiff_d = {{6{s4_sens_q[35]}}, s4_sens_q} - $signed({1'b0, sensi_d});
  assign odiff_d = {{6{s4_off_q[35]}}, s4_off_q} - $signed({1'b0, offi_d});

  // stage 6: D1 * (SENS - SENSI), two partial products
  logic [44:0]        pp_lo_d;
  logic signed [45:0] pp_hi_d;
  logic [44:0]        s6_pp_lo_q;
  logic signed [45:0] s6_pp_hi_q;
  logic signed [41:0] s6_odiff_q;
  logic [TempW-1:0]   s6_tout_q;

  assign pp_lo_d = s5_d1_q * s5_sdiff_q[20:0];
  assign pp_hi_d = $signed({1'b0, s5_d1_q}) * $signed(s5_sdiff_q[41:21]);

  // stage 7: product sum
  logic signed [66:0] prod_d;
  logic signed [66:0] s7_prod_q;
  logic signed [41:0] s7_odiff_q;
  logic [TempW-1:0]   s7_tout_q;

  assign prod_d = {s6_pp_hi_q, 21'b0} + $signed({22'b0, s6_pp_lo_q});

  // stage 8: divide by 2^21 toward zero
  logic signed [45:0] q1_d;
  logic signed [45:0] s8_q1_q;
  logic signed [41:0] s8_odiff_q;
  logic [TempW-1:0]   s8_tout_q;

  assign q1_d = 46'(s7_prod_q / DivSens);

  // stage 9: subtract offset, divide by 2^13 toward zero, saturate
  logic signed [46:0]      r_d;
  logic signed [33:0]      q2_d;
  logic signed [PresW-1:0] pres_d;

  assign r_d  = {s8_q1_q[45], s8_q1_q} - {{5{s8_odiff_q[41]}}, s8_odiff_q};
  assign q2_d = 34'(r_d / DivOff);

  always_comb begin
    if (q2_d > PresMax) begin
      pres_d = PresW'(PresMax);
    end else if (q2_d < PresMin) begin
      pres_d = PresW'(PresMin);
    end else begin
      pres_d = q2_d[PresW-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (stage_en[0]) begin
      s1_d1_q <= raw_pressure_i;
      s1_dt_q <= dt_d;
    end
    if (stage_en[1]) begin
      s2_d1_q  <= s1_d1_q;
      s2_p6_q  <= p6_d;
      s2_p4_q  <= p4_d;
      s2_p3_q  <= p3_d;
      s2_dt2_q <= dt2_full[48:0];
    end
    if (stage_en[2]) begin
      s3_d1_q   <= s2_d1_q;
      s3_dt2_q  <= s2_dt2_q;
      s3_d_q    <= d_d;
      s3_e_q    <= e_d;
      s3_temp_q <= temp_d;
      s3_off_q  <= off_d;
      s3_sens_q <= sens_d;
      s3_hot_q  <= hot_d;
      s3_cold_q <= cold_d;
    end
    if (stage_en[3]) begin
      s4_d1_q   <= s3_d1_q;
      s4_dsq_q  <= dsq_full[36:0];
      s4_esq_q  <= esq_full[36:0];
      s4_off_q  <= s3_off_q;
      s4_sens_q <= s3_sens_q;
      s4_hot_q  <= s3_hot_q;
      s4_cold_q <= s3_cold_q;
      s4_tout_q <= tout_d[TempW-1:0];
    end
    if (stage_en[4]) begin
      s5_d1_q    <= s4_d1_q;
      s5_sdiff_q <= sdiff_d;
      s5_odiff_q <= odiff_d;
      s5_tout_q  <= s4_tout_q;
    end
    if (stage_en[5]) begin
      s6_pp_lo_q <= pp_lo_d;
      s6_pp_hi_q <= pp_hi_d;
      s6_odiff_q <= s5_odiff_q;
      s6_tout_q  <= s5_tout_q;
    end
    if (stage_en[6]) begin
      s7_prod_q  <= prod_d;
      s7_odiff_q <= s6_odiff_q;
      s7_tout_q  <= s6_tout_q;
    end
    if (stage_en[7]) begin
      s8_q1_q    <= q1_d;
      s8_odiff_q <= s7_odiff_q;
      s8_tout_q  <= s7_tout_q;
    end
    if (stage_en[8]) begin
      temperature_centi_o  <= $signed(s8_tout_q);
      pressure_deci_mbar_o <= pres_d;
    end
  end

`ifndef SYNTHESIS
  a_stall_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> ((&valid_q) && out_stall_i))
    else $error("input stalled with a bubble in the pipeline");

  a_take: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> valid_q[0])
    else $error("accepted request lost at first stage");

  a_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q[2] |-> !(s3_hot_q && s3_cold_q))
    else $error("hot and cold range both set");
`endif

endmodule

FILE: verif/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
  import pt_comp_pkg::*;

  localparam logic [CfgIdxW-1:0] RegSpareLo = 3'd6;
  localparam logic [CfgIdxW-1:0] RegSpareHi = 3'd7;
  localparam logic [RawW-1:0]    RawMax     = {RawW{1'b1}};

  typedef struct packed {
    logic [TempW-1:0] temp;
    logic [PresW-1:0] pres;
  } reading_t;

  class reading_checker;
    bit [CalW-1:0] cal [6];
    reading_t      expected_readings [$];
    int            errors;

    function void set_word(logic [CfgIdxW-1:0] idx, logic [CalW-1:0] data);
      if (idx <= RegC6) begin
        cal[idx] = data;
      end
    endfunction

    function reading_t compensate(logic [RawW-1:0] d1, logic [RawW-1:0] d2);
      longint dt, temp, off, sens, dt2, dd, dsq, ti, offi, sensi, e, esq, t, p;
      reading_t r;
      dt    = longint'(d2) - longint'(cal[RegC5]) * 256;
      temp  = TempRef + ((dt * longint'(cal[RegC6])) >>> TempShift);
      off   = longint'(cal[RegC2]) * 65536 + ((longint'(cal[RegC4]) * dt) >>> OffShift);
      sens  = longint'(cal[RegC1]) * 32768 + ((longint'(cal[RegC3]) * dt) >>> SensShift);
      dt2   = dt * dt;
      dd    = temp - TempRef;
      dsq   = dd * dd;
      if (temp > TempRef) begin
        ti    = dt2 >>> TiHotShift;
        offi  = dsq >>> 4;
        sensi = 0;
      end else begin
        ti    = (3 * dt2) >>> TiColdShift;
        offi  = (3 * dsq) >>> 1;
        sensi = (5 * dsq) >>> 3;
        if (temp < -ColdRef) begin
          e     = temp + ColdRef;
          esq   = e * e;
          offi  = offi + 7 * esq;
          sensi = sensi + 4 * esq;
        end
      end
      t = temp - ti;
      p = ((longint'(d1) * (sens - sensi)) / DivSens - (off - offi)) / DivOff;
      if (p > PresMax) p = PresMax;
      if (p < PresMin) p = PresMin;
      r.temp = t[TempW-1:0];
      r.pres = p[PresW-1:0];
      return r;
    endfunction

    function void note_request(logic [RawW-1:0] d1, logic [RawW-1:0] d2);
      expected_readings.push_back(compensate(d1, d2));
    endfunction

    function int pending();
      return expected_readings.size();
    endfunction

    task report(string what);
      $display("mismatch at %0t: %s", $time, what);
      errors++;
    endtask

    task check_reading(logic [TempW-1:0] t, logic [PresW-1:0] p);
      reading_t r;
      if (expected_readings.size() == 0) begin
        report($sformatf("unexpected reading temp %0d pres %0d",
                         $signed(t), $signed(p)));
      end else begin
        r = expected_readings.pop_front();
        if (t !== r.temp) begin
          report($sformatf("temperature %0d, want %0d", $signed(t), $signed(r.temp)));
        end
        if (p !== r.pres) begin
          report($sformatf("pressure %0d, want %0d", $signed(p), $signed(r.pres)));
        end
      end
    endtask
  endclass

  logic                    clk_i = 1'b0;
  logic                    rst_ni;
  logic                    cfg_we_i;
  logic [CfgIdxW-1:0]      cfg_idx_i;
  logic [CalW-1:0]         cfg_data_i;
  logic                    in_valid_i;
  logic                    in_stall_o;
  logic [RawW-1:0]         raw_pressure_i;
  logic [RawW-1:0]         raw_temperature_i;
  logic                    out_valid_o;
  logic                    out_stall_i = 1'b0;
  logic signed [TempW-1:0] temperature_centi_o;
  logic signed [PresW-1:0] pressure_deci_mbar_o;

  int             idle_pct;
  int             stall_pct;
  reading_checker sb;

  pressure_temperature_compensation u_dut (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .cfg_we_i            (cfg_we_i),
    .cfg_idx_i           (cfg_idx_i),
    .cfg_data_i          (cfg_data_i),
    .in_valid_i          (in_valid_i),
    .in_stall_o          (in_stall_o),
    .raw_pressure_i      (raw_pressure_i),
    .raw_temperature_i   (raw_temperature_i),
    .out_valid_o         (out_valid_o),
    .out_stall_i         (out_stall_i),
    .temperature_centi_o (temperature_centi_o),
    .pressure_deci_mbar_o(pressure_deci_mbar_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(negedge clk_i) begin
    out_stall_i <= ($urandom_range(99) < stall_pct);
  end

  always @(posedge clk_i) begin
    if (rst_ni && in_valid_i && !in_stall_o) begin
      sb.note_request(raw_pressure_i, raw_temperature_i);
    end
    if (rst_ni && out_valid_o && !out_stall_i) begin
      sb.check_reading(temperature_centi_o, pressure_deci_mbar_o);
    end
  end

  // all tasks start and end just after a falling edge
  task automatic write_word(logic [CfgIdxW-1:0] idx, logic [CalW-1:0] data);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    sb.set_word(idx, data);
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    @(negedge clk_i);
  endtask

  task automatic load_calibration(logic [CalW-1:0] c1, c2, c3, c4, c5, c6);
    write_word(RegC1, c1);
    write_word(RegC2, c2);
    write_word(RegC3, c3);
    write_word(RegC4, c4);
    write_word(RegC5, c5);
    write_word(RegC6, c6);
  endtask

  task automatic send_request(logic [RawW-1:0] d1, logic [RawW-1:0] d2);
    while ($urandom_range(99) < idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i        <= 1'b1;
    raw_pressure_i    <= d1;
    raw_temperature_i <= d2;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (NumStages + 3) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  // mostly near the reference temperature so the cold and very cold bands get hit
  task automatic run_random(int n);
    int            r;
    logic [RawW-1:0] d1, d2;
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(7))
        0:       d1 = RawMax;
        1:       d1 = '0;
        default: d1 = RawW'($urandom_range(RawMax));
      endcase
      case ($urandom_range(7))
        0:       d2 = RawW'($urandom_range(RawMax));
        1:       d2 = $urandom_range(1) ? RawMax : '0;
        2:       d2 = RawW'(1) << $urandom_range(RawW - 1);
        default: begin
          r = int'({sb.cal[RegC5], 8'h00}) + int'($urandom_range(1 << 22)) - (1 << 21);
          if (r < 0) r = 0;
          if (r > int'(RawMax)) r = int'(RawMax);
          d2 = r[RawW-1:0];
        end
      endcase
      send_request(d1, d2);
    end
  endtask

  initial begin
    logic [RawW-1:0] ref_raw;
    sb                = new();
    rst_ni            = 1'b0;
    cfg_we_i          = 1'b0;
    cfg_idx_i         = RegC1;
    cfg_data_i        = '0;
    in_valid_i        = 1'b0;
    raw_pressure_i    = '0;
    raw_temperature_i = '0;
    idle_pct          = 0;
    stall_pct         = 0;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // calibration words still zero
    send_request('0, '0);
    send_request(RawMax, RawMax);
    wait_drained();

    load_calibration(16'd40127, 16'd36924, 16'd23317, 16'd23282, 16'd33464, 16'd28312);
    ref_raw = {sb.cal[RegC5], 8'h00};
    send_request(24'd6465444, ref_raw);
    send_request(24'd6465444, ref_raw + 24'd1);
    send_request(24'd6465444, ref_raw - 24'd1);
    send_request(RawMax, ref_raw + 24'd300000);
    send_request('0, ref_raw - 24'd500000);
    send_request(24'hAAAAAA, ref_raw - 24'd1036900);
    send_request(24'h555555, ref_raw - 24'd1037100);
    send_request(RawMax, '0);
    send_request('0, RawMax);
    send_request(RawMax, RawMax);
    send_request('0, '0);
    send_request(24'h555555, 24'hAAAAAA);
    send_request(24'hAAAAAA, 24'h555555);
    wait_drained();

    // spare indexes must leave the calibration alone
    write_word(RegSpareLo, 16'hFFFF);
    write_word(RegSpareHi, 16'hFFFF);
    send_request(24'd6465444, 24'd8077636);
    send_request(RawMax, ref_raw - 24'd2000000);

    for (int s = 0; s < 8; s++) begin
      wait_drained();
      case (s)
        0: load_calibration(16'd40127, 16'd36924, 16'd23317, 16'd23282, 16'd33464,
                            16'd28312);
        1: load_calibration(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        2: load_calibration('0, '0, '0, '0, '0, '0);
        3: load_calibration(CalW'($urandom), CalW'($urandom), CalW'($urandom),
                            CalW'($urandom), '0, 16'hFFFF);
        4: load_calibration(CalW'($urandom), CalW'($urandom), CalW'($urandom),
                            CalW'($urandom), 16'hFFFF, CalW'($urandom));
        default: load_calibration(CalW'($urandom), CalW'($urandom), CalW'($urandom),
                                  CalW'($urandom), CalW'($urandom), CalW'($urandom));
      endcase
      for (int m = 0; m < 4; m++) begin
        case (m)
          0: begin idle_pct = 0;  stall_pct = 0;  end
          1: begin idle_pct = 51; stall_pct = 0;  end
          2: begin idle_pct = 0;  stall_pct = 51; end
          default: begin idle_pct = 33; stall_pct = 33; end
        endcase
        run_random(8);
        if (m == 1) wait_drained();
        run_random(8);
      end
    end

    wait_drained();
    if (sb.errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("TEST FAILED");
    $finish;
  end

endmodule
